// File: hdl/sliding_window_digit_product_max_unit_defines.svh
// ----------------------------------------------------------------------------
// sliding window digit product max unit - assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_DIGIT_PRODUCT_MAX_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_DIGIT_PRODUCT_MAX_UNIT_DEFINES_SVH

// same-cycle implication
`define SWDP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("swdp assertion failed");

// next-cycle implication
`define SWDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("swdp assertion failed");

`endif

// File: hdl/swdp_pkg.sv
// ----------------------------------------------------------------------------
// swdp_pkg
// types and constants shared by the sliding window digit product max unit
// ----------------------------------------------------------------------------
`default_nettype none

package swdp_pkg;

	localparam int MAX_SPAN = 16;
	localparam int SPAN_W   = 5;
	localparam int IDX_W    = $clog2(MAX_SPAN);
	localparam int CHARS_W  = $clog2(MAX_SPAN + 1);
	localparam int DIGIT_W  = 4;
	localparam int CHAR_W   = 8;
	localparam int PROD_W   = 51;
	localparam int RESULT_W = 52;

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MULT,
		ST_CMP
	} state_t;

	typedef struct packed {
		logic take_char;
		logic take_end;
		logic mult_step;
		logic cmp;
	} dp_cmd_t;

	typedef struct packed {
		logic win_go;
		logic step_last;
	} dp_status_t;

endpackage

`default_nettype wire

// File: hdl/sliding_window_digit_product_max_unit.sv
// a digit request that completes a window is taken, then its product is built in span multiply
// steps through one 51x4 multiplier, then compared; other requests leave the sequencer idle
// an end request loads the result register at its accept edge, shown the next cycle
// new requests stall while a window runs; an end request also while a result is held
// reset: arst_n clears the span to 1, the string state, the sequencer and the result valid
// ----------------------------------------------------------------------------
// sliding_window_digit_product_max_unit
// largest product of span consecutive decimal digits over a streamed string
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_window_digit_product_max_unit_defines.svh"

module sliding_window_digit_product_max_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_write,
	input  wire logic [swdp_pkg::SPAN_W-1:0]          cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [swdp_pkg::CHAR_W-1:0]          character,
	input  wire logic                                 end_of_string,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [swdp_pkg::RESULT_W-1:0]      largest_product
);

	swdp_pkg::dp_cmd_t    cmd;
	swdp_pkg::dp_status_t status;
	logic                 busy;

	swdp_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.end_of_string (end_of_string),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.cmd           (cmd),
		.busy          (busy)
	);

	swdp_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_data        (cfg_data),
		.character       (character),
		.cmd             (cmd),
		.status          (status),
		.largest_product (largest_product)
	);

	`SWDP_ASSERT_SAME(a_busy_stalls, clk, arst_n, busy, in_stall)
	`SWDP_ASSERT_NEXT(a_end_gives_result, clk, arst_n, in_valid && !in_stall && end_of_string, out_valid)
	`SWDP_ASSERT_SAME(a_negative_is_minus_one, clk, arst_n, out_valid && largest_product[swdp_pkg::RESULT_W-1], &largest_product)

endmodule

`default_nettype wire

// File: hdl/swdp_dpath.sv
// ----------------------------------------------------------------------------
// swdp_dpath
// digit window, shared digit multiplier, running maximum and result register
// ----------------------------------------------------------------------------
`default_nettype none

module swdp_dpath (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     cfg_write,
	input  wire logic [swdp_pkg::SPAN_W-1:0]              cfg_data,
	input  wire logic [swdp_pkg::CHAR_W-1:0]              character,
	input  wire swdp_pkg::dp_cmd_t                        cmd,
	output swdp_pkg::dp_status_t                          status,
	output logic signed [swdp_pkg::RESULT_W-1:0]          largest_product
);

	logic [swdp_pkg::SPAN_W-1:0]                    span_q;
	logic [swdp_pkg::DIGIT_W-1:0]                   window_q [swdp_pkg::MAX_SPAN];
	logic [swdp_pkg::CHARS_W-1:0]                   chars_q;
	logic                                           bad_q;
	logic [swdp_pkg::PROD_W-1:0]                    prod_q;
	logic [swdp_pkg::PROD_W-1:0]                    best_q;
	logic [swdp_pkg::IDX_W-1:0]                     idx_q;
	logic signed [swdp_pkg::RESULT_W-1:0]           result_q;

	logic                                           is_digit;
	logic [swdp_pkg::DIGIT_W-1:0]                   digit;
	logic [swdp_pkg::CHARS_W-1:0]                   chars_next;
	logic                                           span_ok;
	logic [swdp_pkg::PROD_W+swdp_pkg::DIGIT_W-1:0]  mul;
	logic                                           short_str;

	assign is_digit   = (character >= swdp_pkg::CHAR_ZERO) && (character <= swdp_pkg::CHAR_NINE);
	assign digit      = swdp_pkg::DIGIT_W'(character - swdp_pkg::CHAR_ZERO);
	assign chars_next = (chars_q == swdp_pkg::CHARS_W'(swdp_pkg::MAX_SPAN)) ?
		chars_q : chars_q + swdp_pkg::CHARS_W'(1);
	assign span_ok    = (span_q != '0) && (span_q <= swdp_pkg::SPAN_W'(swdp_pkg::MAX_SPAN));
	assign mul        = prod_q * window_q[idx_q];
	assign short_str  = swdp_pkg::SPAN_W'(chars_q) < span_q;

	assign status.win_go    = is_digit && span_ok && (swdp_pkg::SPAN_W'(chars_next) >= span_q);
	assign status.step_last = swdp_pkg::SPAN_W'(idx_q) == (span_q - swdp_pkg::SPAN_W'(1));

	assign largest_product = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q <= swdp_pkg::SPAN_W'(1);
		end else if (cfg_write) begin
			span_q <= cfg_data;
		end
	end

	// string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < swdp_pkg::MAX_SPAN; i++) begin
				window_q[i] <= '0;
			end
			chars_q <= '0;
			bad_q   <= 1'b0;
			best_q  <= '0;
		end else if (cmd.take_end) begin
			for (int i = 0; i < swdp_pkg::MAX_SPAN; i++) begin
				window_q[i] <= '0;
			end
			chars_q <= '0;
			bad_q   <= 1'b0;
			best_q  <= '0;
		end else if (cmd.take_char) begin
			chars_q <= chars_next;
			if (is_digit) begin
				for (int i = swdp_pkg::MAX_SPAN - 1; i > 0; i--) begin
					window_q[i] <= window_q[i-1];
				end
				window_q[0] <= digit;
			end else begin
				bad_q <= 1'b1;
			end
		end else if (cmd.cmp && (prod_q > best_q)) begin
			best_q <= prod_q;
		end
	end

	// product restarts at 1 on a taken character, then one digit per cycle through the multiplier
	always_ff @(posedge clk) begin
		if (cmd.take_char) begin
			prod_q <= swdp_pkg::PROD_W'(1);
			idx_q  <= '0;
		end else if (cmd.mult_step) begin
			prod_q <= mul[swdp_pkg::PROD_W-1:0];
			idx_q  <= idx_q + swdp_pkg::IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_end) begin
			priority if (bad_q || !span_ok && (span_q != '0) || short_str) begin
				result_q <= '1;
			end else if (span_q == '0) begin
				result_q <= swdp_pkg::RESULT_W'(1);
			end else begin
				result_q <= {1'b0, best_q};
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/swdp_ctrl.sv
// ----------------------------------------------------------------------------
// swdp_ctrl
// request handshakes and sequencing of the window product steps
// ----------------------------------------------------------------------------
`default_nettype none

module swdp_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 end_of_string,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	input  wire swdp_pkg::dp_status_t status,
	output swdp_pkg::dp_cmd_t         cmd,
	output logic                      busy
);

	swdp_pkg::state_t state_q;
	swdp_pkg::state_t state_next;
	logic             out_valid_q;
	logic             accept;

	assign busy      = state_q != swdp_pkg::ST_IDLE;
	assign in_stall  = busy || (out_valid_q && out_stall && end_of_string);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			swdp_pkg::ST_IDLE: begin
				if (accept && !end_of_string && status.win_go) begin
					state_next = swdp_pkg::ST_MULT;
				end
			end
			swdp_pkg::ST_MULT: begin
				if (status.step_last) begin
					state_next = swdp_pkg::ST_CMP;
				end
			end
			swdp_pkg::ST_CMP: begin
				state_next = swdp_pkg::ST_IDLE;
			end
			default: begin
				state_next = swdp_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			swdp_pkg::ST_IDLE: begin
				cmd.take_char = accept && !end_of_string;
				cmd.take_end  = accept && end_of_string;
			end
			swdp_pkg::ST_MULT: begin
				cmd.mult_step = 1'b1;
			end
			swdp_pkg::ST_CMP: begin
				cmd.cmp = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= swdp_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.take_end) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire
